FILE: rtl/q32d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q32.32 divider package
// Shared word type and constants for the Newton-Raphson Q32.32 divider.
// ----------------------------------------------------------------------------
package q32d_pkg;

  localparam int Q_WIDTH = 64;
  localparam int HALF_WIDTH = 32;
  localparam int DEFAULT_NEWTON_STEPS = 5;

  typedef logic [Q_WIDTH-1:0] q_word_t;
  typedef logic [HALF_WIDTH-1:0] half_word_t;

  localparam q_word_t Q_ZERO = 64'h0000_0000_0000_0000;
  localparam q_word_t Q_TWO = 64'h0000_0002_0000_0000;
  localparam q_word_t Q_SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam q_word_t Q_SAT_NEG = 64'h8000_0001_0000_0000;

endpackage

FILE: rtl/q32d_est.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal seed
// Gives a power-of-two first estimate of 1/b from the leading one of b.
// ----------------------------------------------------------------------------
module q32d_est import q32d_pkg::*; (
  input  q_word_t b,
  output q_word_t x
);

  half_word_t b_hi;
  half_word_t b_lo;
  logic [4:0] hi_msb;
  logic [4:0] lo_clz;

  assign b_hi = b[63:32];
  assign b_lo = b[31:0];

  always_comb begin
    hi_msb = 5'd0;
    lo_clz = 5'd0;
    for (int i = 0; i < HALF_WIDTH; i++) begin
      if (b_hi[i]) begin
        hi_msb = 5'(i);
      end
      if (b_lo[i]) begin
        lo_clz = 5'(HALF_WIDTH - 1 - i);
      end
    end
  end

  // An integer part below 2^31 gives a seed below one; otherwise the seed grows
  // with the leading zeros of the fraction, capped at two to the thirtieth.
  always_comb begin
    if ((b_hi != '0) && !b_hi[HALF_WIDTH-1]) begin
      x = {32'h0, 32'h8000_0000 >> hi_msb};
    end else if (lo_clz >= 5'd30) begin
      x = {32'h4000_0000, 32'h0};
    end else begin
      x = {32'h1 << (6'(lo_clz) + 6'd1), 32'h0};
    end
  end

endmodule

FILE: rtl/q32d_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared Q32.32 multiplier
// Signed 64 by 64 multiply built from one 32 by 32 multiplier over six
// partial steps; the result is bits 95 to 32 of the signed product.
// ----------------------------------------------------------------------------
module q32d_mul import q32d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  q_word_t a,
  input  q_word_t b,
  output logic    done,
  output q_word_t result
);

  localparam logic [2:0] PH_LL = 3'd0;
  localparam logic [2:0] PH_LH = 3'd1;
  localparam logic [2:0] PH_HL = 3'd2;
  localparam logic [2:0] PH_HH = 3'd3;
  localparam logic [2:0] PH_CA = 3'd4;
  localparam logic [2:0] PH_CB = 3'd5;
  localparam logic [2:0] PH_END = 3'd6;

  localparam logic [1:0] OFF_0 = 2'd0;
  localparam logic [1:0] OFF_32 = 2'd1;
  localparam logic [1:0] OFF_64 = 2'd2;

  logic         busy;
  logic [2:0]   phase;
  logic         pp_vld;
  logic         pp_last;
  logic [1:0]   pp_off;
  q_word_t      pp;
  logic [127:0] acc;

  half_word_t   ma;
  half_word_t   mb;
  q_word_t      product;
  q_word_t      pp_next;
  logic [1:0]   off_next;
  logic [127:0] addend;

  always_comb begin
    ma = a[31:0];
    mb = b[31:0];
    off_next = OFF_64;
    case (phase)
      PH_LL: begin
        ma = a[31:0];
        mb = b[31:0];
        off_next = OFF_0;
      end
      PH_LH: begin
        ma = a[31:0];
        mb = b[63:32];
        off_next = OFF_32;
      end
      PH_HL: begin
        ma = a[63:32];
        mb = b[31:0];
        off_next = OFF_32;
      end
      PH_HH: begin
        ma = a[63:32];
        mb = b[63:32];
        off_next = OFF_64;
      end
      default: begin
        ma = a[31:0];
        mb = b[31:0];
        off_next = OFF_64;
      end
    endcase
  end

  assign product = 64'(ma) * 64'(mb);

  // The last two steps turn the unsigned product into a signed one.
  always_comb begin
    case (phase)
      PH_CA:   pp_next = a[63] ? (Q_ZERO - b) : Q_ZERO;
      PH_CB:   pp_next = b[63] ? (Q_ZERO - a) : Q_ZERO;
      default: pp_next = product;
    endcase
  end

  always_comb begin
    case (pp_off)
      OFF_0:   addend = {64'h0, pp};
      OFF_32:  addend = {32'h0, pp, 32'h0};
      default: addend = {pp, 64'h0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase <= PH_LL;
      pp_vld <= 1'b0;
      pp_last <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        phase <= PH_LL;
        pp_vld <= 1'b0;
        pp_last <= 1'b0;
      end else if (busy) begin
        if (phase != PH_END) begin
          pp_vld <= 1'b1;
          pp_last <= (phase == PH_CB);
          phase <= phase + 3'd1;
        end else begin
          pp_vld <= 1'b0;
        end
        if (pp_vld && pp_last) begin
          busy <= 1'b0;
          done <= 1'b1;
          pp_vld <= 1'b0;
          pp_last <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= '0;
    end else if (busy && pp_vld) begin
      acc <= acc + addend;
    end
    if (busy && (phase != PH_END)) begin
      pp <= pp_next;
      pp_off <= off_next;
    end
  end

  assign result = acc[95:32];

endmodule

FILE: rtl/q32_32_newton_raphson_divider_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q32.32 Newton-Raphson divider
// Divides two signed Q32.32 words by a reciprocal refined with Newton steps.
// ----------------------------------------------------------------------------
// One division uses the single shared 32 by 32 multiplier for each of its
// 2 * NEWTON_STEPS + 1 Q32.32 multiplies, which depend on one another; each
// spends six steps on it, with a registered accumulate behind. A zero
// divisor skips the arithmetic: the state goes straight to S_DONE and the
// saturated quotient is then loaded into the output register. The block
// takes one division at a time; a finished result may wait in the output
// register while the next division runs.
module q32_32_newton_raphson_divider_top import q32d_pkg::*; #(
  parameter int NEWTON_STEPS = DEFAULT_NEWTON_STEPS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] dividend,
  input  logic signed [63:0] divisor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] quotient,
  output logic               divide_by_zero
);

  localparam int IterW = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
  localparam logic [IterW-1:0] LastIter = IterW'(NEWTON_STEPS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EST = 3'd1;
  localparam logic [2:0] S_BX = 3'd2;
  localparam logic [2:0] S_XT = 3'd3;
  localparam logic [2:0] S_AX = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state;
  logic [IterW-1:0] iter;
  logic             issued;
  q_word_t          a_mag;
  q_word_t          b_mag;
  logic             neg_q;
  q_word_t          x;
  q_word_t          t;
  q_word_t          res;
  logic             dz;

  logic             in_xfer;
  logic             out_load;
  logic             mul_state;
  logic             mul_start;
  logic             mul_done;
  q_word_t          mul_a;
  q_word_t          mul_b;
  q_word_t          mul_result;
  q_word_t          seed;

  assign in_ready = (state == S_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign mul_state = (state == S_BX) || (state == S_XT) || (state == S_AX);
  assign mul_start = mul_state && !issued;

  always_comb begin
    case (state)
      S_XT: begin
        mul_a = x;
        mul_b = t;
      end
      S_AX: begin
        mul_a = a_mag;
        mul_b = x;
      end
      default: begin
        mul_a = b_mag;
        mul_b = x;
      end
    endcase
  end

  q32d_est u_est (
    .b (b_mag),
    .x (seed)
  );

  q32d_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter <= '0;
      issued <= 1'b0;
    end else begin
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= (divisor == '0) ? S_DONE : S_EST;
          end
        end
        S_EST: begin
          iter <= '0;
          state <= S_BX;
        end
        S_BX: begin
          if (mul_done) begin
            state <= S_XT;
          end
        end
        S_XT: begin
          if (mul_done) begin
            iter <= iter + 1'b1;
            state <= (iter == LastIter) ? S_AX : S_BX;
          end
        end
        S_AX: begin
          if (mul_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_mag <= dividend[63] ? (Q_ZERO - q_word_t'(dividend)) : q_word_t'(dividend);
      b_mag <= divisor[63] ? (Q_ZERO - q_word_t'(divisor)) : q_word_t'(divisor);
      neg_q <= dividend[63] ^ divisor[63];
      dz <= (divisor == '0);
      res <= dividend[63] ? Q_SAT_NEG : Q_SAT_POS;
    end
    if (state == S_EST) begin
      x <= seed;
    end
    if ((state == S_BX) && mul_done) begin
      t <= Q_TWO - mul_result;
    end
    if ((state == S_XT) && mul_done) begin
      x <= mul_result;
    end
    if ((state == S_AX) && mul_done) begin
      res <= neg_q ? (Q_ZERO - mul_result) : mul_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      quotient <= res;
      divide_by_zero <= dz;
    end
  end

  a_done_in_mul_state : assert property (@(posedge clk) disable iff (rst)
    mul_done |-> mul_state)
    else $error("Multiplier finished outside a multiply state.");

  a_zero_skips : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (divisor == '0)) |=> (state == S_DONE))
    else $error("A zero divisor did not go straight to the result.");

  a_nonzero_seeds : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (divisor != '0)) |=> (state == S_EST))
    else $error("A nonzero divisor did not start the seed step.");

  a_dz_saturates : assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> ((quotient == Q_SAT_POS) || (quotient == Q_SAT_NEG)))
    else $error("A zero divisor gave an unsaturated quotient.");

  a_load_fills_output : assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == S_IDLE)))
    else $error("A finished result was not moved to the output register.");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q32.32 Newton-Raphson divider testbench
// Sends signed Q32.32 dividend and divisor pairs through the valid/ready input
// channel and checks each quotient and divide-by-zero flag against a typed
// value or a bit-exact reciprocal model. Corner cases come first, then random
// operands. Both channels idle at random, with calm stretches between.
// ----------------------------------------------------------------------------
module tb;
  import q32d_pkg::*;

  localparam int  CLK_HALF = 10;
  localparam int  RESET_CYCLES = 9;
  localparam int  RANDOM_ITEMS = 1926;
  localparam int  MAX_IDLE = 18;
  localparam int  DRAIN_CYCLES = 120;
  localparam int  CYCLE_LIMIT = 1_500_000;
  localparam int  REPORT_LIMIT = 10;
  localparam int  SEED_CAP_EXP = 30;
  localparam int  ROWS = 24;

  localparam q_word_t Q_MIN = 64'h8000_0000_0000_0000;
  localparam q_word_t Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam q_word_t Q_ONE = 64'h0000_0001_0000_0000;
  localparam q_word_t Q_LSB = 64'h0000_0000_0000_0001;
  localparam q_word_t Q_SEED_CAP = 64'h4000_0000_0000_0000;
  localparam half_word_t HALF_TOP = 32'h8000_0000;

  typedef struct packed {
    q_word_t quotient;
    logic    div_zero;
  } quotient_t;

  typedef struct packed {
    q_word_t   num;
    q_word_t   den;
    logic      typed;
    quotient_t want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  logic signed [63:0] dividend = '0;
  logic signed [63:0] divisor = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  logic signed [63:0] quotient;
  logic    divide_by_zero;

  quotient_t pending_quotients[$];
  int        cycle_count = 0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        zero_div_seen = 0;

  stim_row_t corner_rows [ROWS] = '{
    '{Q_ZERO, Q_ZERO, 1'b1, '{Q_SAT_POS, 1'b1}},
    '{64'h0000_0005_0000_0000, Q_ZERO, 1'b1, '{Q_SAT_POS, 1'b1}},
    '{64'hFFFF_FFFD_0000_0000, Q_ZERO, 1'b1, '{Q_SAT_NEG, 1'b1}},
    '{Q_MIN, Q_ZERO, 1'b1, '{Q_SAT_NEG, 1'b1}},
    '{Q_MAX, Q_ZERO, 1'b1, '{Q_SAT_POS, 1'b1}},
    '{Q_ZERO, Q_ONE, 1'b1, '{Q_ZERO, 1'b0}},
    '{Q_ONE, Q_ONE, 1'b0, '0},
    '{64'h0000_0006_0000_0000, 64'h0000_0002_0000_0000, 1'b0, '0},
    '{64'hFFFF_FFF8_8000_0000, 64'h0000_0002_8000_0000, 1'b0, '0},
    '{64'h0000_0007_0000_0000, 64'hFFFF_FFFF_8000_0000, 1'b0, '0},
    '{64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFD_0000_0000, 1'b0, '0},
    '{Q_MAX, Q_MAX, 1'b0, '0},
    '{Q_MIN, Q_MIN, 1'b0, '0},
    '{Q_MIN, Q_ONE, 1'b0, '0},
    '{Q_ONE, Q_MIN, 1'b0, '0},
    '{Q_ONE, Q_LSB, 1'b0, '0},
    '{Q_ONE, 64'h0000_0000_0000_0002, 1'b0, '0},
    '{Q_ONE, 64'h0000_0000_0000_0004, 1'b0, '0},
    '{Q_ONE, 64'h0000_0000_0000_0008, 1'b0, '0},
    '{Q_ONE, 64'h0000_0000_8000_0000, 1'b0, '0},
    '{Q_ONE, 64'h7FFF_FFFF_0000_0000, 1'b0, '0},
    '{Q_MAX, Q_LSB, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
  };

  q32_32_newton_raphson_divider_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .dividend       (dividend),
    .divisor        (divisor),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending_quotients.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic q_word_t q_mul(q_word_t a, q_word_t b);
    logic signed [127:0] wide_a;
    logic signed [127:0] wide_b;
    logic signed [127:0] product;
    wide_a = $signed(a);
    wide_b = $signed(b);
    product = wide_a * wide_b;
    return product[95:32];
  endfunction

  function automatic q_word_t reciprocal_seed(q_word_t b);
    half_word_t int_part;
    half_word_t frac_part;
    int         shift;
    int_part = b[63:32];
    frac_part = b[31:0];
    shift = 0;
    if (int_part != '0 && !int_part[31]) begin
      while (int_part > 32'd1) begin
        int_part = int_part >> 1;
        shift++;
      end
      return q_word_t'(HALF_TOP >> shift);
    end
    while (frac_part != '0 && !frac_part[31]) begin
      frac_part = frac_part << 1;
      shift++;
    end
    if (shift + 1 > SEED_CAP_EXP) return Q_SEED_CAP;
    return q_word_t'(64'd1 << (shift + 1 + HALF_WIDTH));
  endfunction

  function automatic quotient_t predict_quotient(q_word_t num, q_word_t den);
    logic      num_neg;
    logic      den_neg;
    q_word_t   num_mag;
    q_word_t   den_mag;
    q_word_t   recip;
    quotient_t res;
    num_neg = num[63];
    den_neg = den[63];
    num_mag = num_neg ? Q_ZERO - num : num;
    den_mag = den_neg ? Q_ZERO - den : den;
    if (den_mag == Q_ZERO) begin
      res.quotient = num_neg ? Q_SAT_NEG : Q_SAT_POS;
      res.div_zero = 1'b1;
      return res;
    end
    recip = reciprocal_seed(den_mag);
    for (int i = 0; i < DEFAULT_NEWTON_STEPS; i++) begin
      recip = q_mul(recip, Q_TWO - q_mul(den_mag, recip));
    end
    recip = q_mul(num_mag, recip);
    res.quotient = (num_neg != den_neg) ? Q_ZERO - recip : recip;
    res.div_zero = 1'b0;
    return res;
  endfunction

  function automatic q_word_t random_operand();
    q_word_t    val;
    half_word_t int_part;
    case ($urandom_range(0, 9))
      0, 1, 2: val = {$urandom(), $urandom()};
      3, 4: begin
        int_part = half_word_t'($urandom_range(0, 200)) - 32'd100;
        val = {int_part, $urandom()};
      end
      5: val = q_word_t'({$urandom(), $urandom()}) >> $urandom_range(0, 63);
      6: val = 64'd1 << $urandom_range(0, 62);
      7: begin
        case ($urandom_range(0, 3))
          0: val = Q_MIN;
          1: val = Q_MAX;
          2: val = Q_ONE;
          default: val = Q_LSB;
        endcase
      end
      default: val = {$urandom() >> $urandom_range(0, 31), $urandom()};
    endcase
    if ($urandom_range(0, 1) == 1) val = Q_ZERO - val;
    return val;
  endfunction

  function automatic int idle_cycles(logic calm);
    return calm ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  task automatic note_mismatch(string field, q_word_t want, q_word_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("Mismatch on result %0d, %s: expected %h, got %h", results_seen, field, want, got);
    end
  endtask

  task automatic send_division(q_word_t num, q_word_t den, quotient_t want, logic calm);
    int gap;
    gap = idle_cycles(calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    dividend <= num;
    divisor <= den;
    do @(posedge clk); while (!in_ready);
    pending_quotients.push_back(want);
  endtask

  initial begin
    int  gap;
    logic calm;
    quotient_t want;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (results_seen % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = idle_cycles(calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (divide_by_zero) zero_div_seen++;
      if (pending_quotients.size() == 0) begin
        note_mismatch("unexpected transfer", Q_ZERO, quotient);
      end else begin
        want = pending_quotients.pop_front();
        if (q_word_t'(quotient) !== want.quotient) begin
          note_mismatch("quotient", want.quotient, quotient);
        end
        if (divide_by_zero !== want.div_zero) begin
          note_mismatch("divide_by_zero", q_word_t'(want.div_zero), q_word_t'(divide_by_zero));
        end
      end
    end
  end

  initial begin
    q_word_t   num;
    q_word_t   den;
    quotient_t want;
    logic      calm;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    calm = 1'b0;
    foreach (corner_rows[i]) begin
      want = corner_rows[i].typed ? corner_rows[i].want
                                  : predict_quotient(corner_rows[i].num, corner_rows[i].den);
      send_division(corner_rows[i].num, corner_rows[i].den, want, 1'b0);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      num = random_operand();
      den = ($urandom_range(0, 31) == 0) ? Q_ZERO : random_operand();
      send_division(num, den, predict_quotient(num, den), calm);
    end
    in_valid <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d quotients, %0d of them divisions by zero, with %0d mismatches.",
             results_seen, zero_div_seen, mismatches);
    if (mismatches == 0 && pending_quotients.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
